// ===== sv/kfpv_pkg.sv =====
// ----------------------------------------------------------------------------
// kfpv_pkg: shared types and constants for the position/velocity filter
// holds the data width, a saturation helper, the register and unit operation codes
// ----------------------------------------------------------------------------
package kfpv_pkg;
    localparam int DW = 32;

    typedef logic signed [DW-1:0] t_q;

    localparam logic [2:0] REG_STEP_TIME     = 3'd0;
    localparam logic [2:0] REG_ACCEL_COMMAND = 3'd1;
    localparam logic [2:0] REG_MEAS_VARIANCE = 3'd2;
    localparam logic [2:0] REG_PROC_VAR_PP   = 3'd3;
    localparam logic [2:0] REG_PROC_VAR_PV   = 3'd4;
    localparam logic [2:0] REG_PROC_VAR_VV   = 3'd5;
    localparam logic [2:0] REG_MEAS_GAIN_POS = 3'd6;
    localparam logic [2:0] REG_MEAS_GAIN_VEL = 3'd7;

    // shared unit operation codes
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // saturate a 64 bit value to 32 bits
    function automatic logic [DW:0] sat64(input logic signed [63:0] v);
        logic [DW:0] r;
        if (v > 64'sd2147483647) r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -64'sd2147483648) r = {1'b1, 32'h8000_0000};
        else r = {1'b0, v[DW-1:0]};
        return r;
    endfunction
endpackage

// ===== sv/kfpv_alu.sv =====
// ----------------------------------------------------------------------------
// kfpv_alu: shared arithmetic unit
// saturating add, subtract, multiply (result registered) and a restoring divider
// that retires one quotient bit per cycle
// ----------------------------------------------------------------------------
module kfpv_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_op,
    input  kfpv_pkg::t_q      i_a,
    input  kfpv_pkg::t_q      i_b,
    output logic              o_done,
    output kfpv_pkg::t_q      o_res,
    output logic              o_sat
);
    import kfpv_pkg::*;

    localparam int NW = DW + FRAC_BITS;   // dividend bits
    localparam int CW = $clog2(NW + 1);

    logic                  r_busy;
    logic [CW-1:0]         r_cnt;
    logic [NW-1:0]         r_num;
    logic [NW-1:0]         r_quo;
    logic [DW:0]           r_rem;
    logic [DW-1:0]         r_den;
    logic                  r_neg;
    logic                  r_done;
    t_q                    r_res;
    logic                  r_sat;

    logic signed [63:0]    w_prod;
    logic signed [63:0]    w_shift;
    logic signed [63:0]    w_sum;
    logic [DW:0]           w_sat;
    logic [DW:0]           w_trial;
    logic [DW:0]           w_rem_sh;
    logic signed [NW:0]    w_q;
    logic signed [63:0]    w_qx;
    logic [DW:0]           w_qsat;

    assign w_prod  = 64'(i_a) * 64'(i_b);
    assign w_shift = w_prod >>> FRAC_BITS;
    assign w_sum   = (i_op == OP_SUB) ? 64'(i_a) - 64'(i_b) : 64'(i_a) + 64'(i_b);
    assign w_sat   = sat64((i_op == OP_MUL) ? w_shift : w_sum);

    assign w_rem_sh = {r_rem[DW-1:0], r_num[NW-1]};
    assign w_trial  = w_rem_sh - {1'b0, r_den};
    assign w_q      = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_qx     = 64'(w_q);
    assign w_qsat   = sat64(w_qx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                if (i_op == OP_DIV) begin
                    r_busy <= 1'b1;
                    r_cnt  <= CW'(NW);
                end else begin
                    r_done <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_res <= t_q'(w_sat[DW-1:0]);
            r_sat <= w_sat[DW];
            r_num <= NW'((i_a[DW-1] ? 64'(-64'(i_a)) : 64'(i_a)) << FRAC_BITS);
            r_den <= i_b[DW-1] ? DW'(-i_b) : DW'(i_b);
            r_neg <= i_a[DW-1] ^ i_b[DW-1];
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_num <= {r_num[NW-2:0], 1'b0};
                if (!w_trial[DW]) begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end
            end else begin
                r_res <= t_q'(w_qsat[DW-1:0]);
                r_sat <= w_qsat[DW];
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_sat  = r_sat;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("alu done held two cycles");
    a_busy_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt != '0) |=> !r_done || $past(r_cnt) == 1)
        else $error("alu done during division");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !r_busy && i_op == OP_DIV) |=> r_busy)
        else $error("divider did not start");
endmodule

// ===== sv/kalman_filter_position_velocity.sv =====
// ----------------------------------------------------------------------------
// kalman_filter_position_velocity: two-state fixed point tracking filter
// position/velocity predictor-form filter on one shared arithmetic unit
// ----------------------------------------------------------------------------
// usage
//  - input channel: one measured position per transaction (valid/ready)
//  - output channel: position, velocity, innovation and math fault flag
//  - config: write enable, index and data; write only while idle
//  - each sample runs a fixed microprogram of 44 steps through one shared
//    unit; add/sub/mul results are registered, the two divisions run on
//    its bit-serial divider
//  - when the innovation variance is zero both divisions are skipped, the
//    gains are forced to zero and the math fault flag is set
//  - one sample in flight at a time
//  - ready is low from acceptance until the result transaction is taken
//  - when the receiver stalls the result stays in the output register
//  - reset: estimates and covariance cleared, registers to defaults; the
//    first sample loads covariance from the process noise registers
// ----------------------------------------------------------------------------
module kalman_filter_position_velocity #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic signed [31:0] i_measured_position,
    output logic          o_valid,
    input  logic          i_ready,
    output logic signed [31:0] o_position_estimate,
    output logic signed [31:0] o_velocity_estimate,
    output logic signed [31:0] o_innovation,
    output logic          o_math_fault
);
    import kfpv_pkg::*;

    // scratch register file slots
    localparam logic [4:0] R_T = 5'd0, R_U = 5'd1, R_SZ = 5'd2, R_WPP = 5'd3,
        R_WPV = 5'd4, R_WVV = 5'd5, R_C0 = 5'd6, R_C1 = 5'd7, R_Y = 5'd8,
        R_XP = 5'd9, R_XV = 5'd10, R_PP = 5'd11, R_PV = 5'd12, R_VV = 5'd13,
        R_B0 = 5'd14, R_A = 5'd15, R_B = 5'd16, R_INN = 5'd17, R_H0 = 5'd18,
        R_H1 = 5'd19, R_S = 5'd20, R_G0 = 5'd21, R_K0 = 5'd22, R_K1 = 5'd23,
        R_M00 = 5'd24, R_M01 = 5'd25, R_APP = 5'd26, R_ZERO = 5'd27;
    localparam int NREG = 28;

    localparam logic [1:0] S_IDLE = 2'd0, S_ISSUE = 2'd1, S_WAIT = 2'd2,
        S_OUT = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] a;
        logic [4:0] b;
        logic [4:0] d;
    } t_uop;

    function automatic t_uop uop(input logic [5:0] pc);
        case (pc)
            6'd0:  uop = '{OP_MUL, R_T, R_T, R_B0};
            6'd1:  uop = '{OP_MUL, R_T, R_XV, R_A};      // t*v (xv still est)
            6'd2:  uop = '{OP_ADD, R_XP, R_A, R_XP};
            6'd3:  uop = '{OP_MUL, R_B0, R_U, R_A};      // b0 halved before
            6'd4:  uop = '{OP_ADD, R_XP, R_A, R_XP};
            6'd5:  uop = '{OP_MUL, R_T, R_U, R_A};
            6'd6:  uop = '{OP_ADD, R_XV, R_A, R_XV};
            6'd7:  uop = '{OP_MUL, R_C0, R_XP, R_A};
            6'd8:  uop = '{OP_MUL, R_C1, R_XV, R_B};
            6'd9:  uop = '{OP_ADD, R_A, R_B, R_A};
            6'd10: uop = '{OP_SUB, R_Y, R_A, R_INN};
            6'd11: uop = '{OP_MUL, R_PP, R_C0, R_A};
            6'd12: uop = '{OP_MUL, R_PV, R_C1, R_B};
            6'd13: uop = '{OP_ADD, R_A, R_B, R_H0};
            6'd14: uop = '{OP_MUL, R_PV, R_C0, R_A};
            6'd15: uop = '{OP_MUL, R_VV, R_C1, R_B};
            6'd16: uop = '{OP_ADD, R_A, R_B, R_H1};
            6'd17: uop = '{OP_MUL, R_C0, R_H0, R_A};
            6'd18: uop = '{OP_MUL, R_C1, R_H1, R_B};
            6'd19: uop = '{OP_ADD, R_A, R_B, R_A};
            6'd20: uop = '{OP_ADD, R_A, R_SZ, R_S};
            6'd21: uop = '{OP_MUL, R_T, R_H1, R_A};
            6'd22: uop = '{OP_ADD, R_H0, R_A, R_G0};
            6'd23: uop = '{OP_DIV, R_G0, R_S, R_K0};
            6'd24: uop = '{OP_DIV, R_H1, R_S, R_K1};
            6'd25: uop = '{OP_MUL, R_K0, R_INN, R_A};
            6'd26: uop = '{OP_ADD, R_XP, R_A, R_XP};
            6'd27: uop = '{OP_MUL, R_K1, R_INN, R_A};
            6'd28: uop = '{OP_ADD, R_XV, R_A, R_XV};
            6'd29: uop = '{OP_MUL, R_T, R_PV, R_A};
            6'd30: uop = '{OP_ADD, R_PP, R_A, R_M00};
            6'd31: uop = '{OP_MUL, R_T, R_VV, R_A};
            6'd32: uop = '{OP_ADD, R_PV, R_A, R_M01};
            6'd33: uop = '{OP_MUL, R_T, R_M01, R_A};
            6'd34: uop = '{OP_ADD, R_M00, R_A, R_APP};
            6'd35: uop = '{OP_MUL, R_K0, R_G0, R_A};
            6'd36: uop = '{OP_SUB, R_APP, R_A, R_A};
            6'd37: uop = '{OP_ADD, R_A, R_WPP, R_PP};
            6'd38: uop = '{OP_MUL, R_K0, R_H1, R_A};
            6'd39: uop = '{OP_SUB, R_M01, R_A, R_M01};
            default: uop = '{OP_ADD, R_ZERO, R_ZERO, R_ZERO};
        endcase
    endfunction

    // tail steps kept outside the table to stay within 40 entries
    localparam logic [5:0] PC_PV2 = 6'd40, PC_K1G = 6'd41, PC_VV1 = 6'd42,
        PC_VV2 = 6'd43, PC_END = 6'd44;

    // configuration registers
    logic [30:0] r_step_time, r_meas_variance, r_pp, r_vv;
    logic [31:0] r_u, r_pv, r_c0, r_c1;

    t_q          r_est_p, r_est_v, r_cov_pp, r_cov_pv, r_cov_vv;
    logic        r_first;
    t_q          r_rf [NREG];
    logic [1:0]  r_state;
    logic [5:0]  r_pc;
    logic        r_fault;
    logic        r_start;
    t_q          r_pos, r_vel, r_inn;
    logic        r_mfault;

    t_uop        w_u;
    logic        w_done;
    t_q          w_res;
    logic        w_sat;
    t_q          w_a, w_b;
    logic [1:0]  w_op;
    logic [4:0]  w_d;
    t_q          w_wr;
    logic        w_div_zero;

    always_comb begin
        w_u = uop(r_pc);
        case (r_pc)
            PC_PV2: w_u = '{OP_ADD, R_M01, R_WPV, R_PV};
            PC_K1G: w_u = '{OP_MUL, R_K1, R_H1, R_A};
            PC_VV1: w_u = '{OP_SUB, R_VV, R_A, R_A};
            PC_VV2: w_u = '{OP_ADD, R_A, R_WVV, R_VV};
            default: ;
        endcase
    end

    assign w_op = w_u.op;
    assign w_d  = w_u.d;
    assign w_a  = r_rf[w_u.a];
    assign w_b  = r_rf[w_u.b];
    assign w_div_zero = (w_op == OP_DIV) && (w_b == '0);
    // b0 = (t*t)/2 truncated toward zero
    assign w_wr = (r_pc == 6'd0) ? t_q'((64'(w_res) + (w_res[31] ? 64'sd1 : 64'sd0)) >>> 1)
                                 : w_res;

    kfpv_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_res   (w_res),
        .o_sat   (w_sat)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time     <= 31'd65536;
            r_u             <= 32'd65536;
            r_meas_variance <= 31'd6553600;
            r_pp            <= 31'd655;
            r_pv            <= 32'd1311;
            r_vv            <= 31'd2621;
            r_c0            <= 32'd65536;
            r_c1            <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_STEP_TIME:     r_step_time     <= i_cfg_data[30:0];
                REG_ACCEL_COMMAND: r_u             <= i_cfg_data;
                REG_MEAS_VARIANCE: r_meas_variance <= i_cfg_data[30:0];
                REG_PROC_VAR_PP:   r_pp            <= i_cfg_data[30:0];
                REG_PROC_VAR_PV:   r_pv            <= i_cfg_data;
                REG_PROC_VAR_VV:   r_vv            <= i_cfg_data[30:0];
                REG_MEAS_GAIN_POS: r_c0            <= i_cfg_data;
                REG_MEAS_GAIN_VEL: r_c1            <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_start <= 1'b0;
            r_first <= 1'b1;
            r_est_p <= '0;
            r_est_v <= '0;
            r_cov_pp <= '0;
            r_cov_pv <= '0;
            r_cov_vv <= '0;
            r_fault <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        // load working copies of state and registers
                        r_rf[R_T]   <= t_q'({1'b0, r_step_time});
                        r_rf[R_U]   <= t_q'(r_u);
                        r_rf[R_SZ]  <= t_q'({1'b0, r_meas_variance});
                        r_rf[R_WPP] <= t_q'({1'b0, r_pp});
                        r_rf[R_WPV] <= t_q'(r_pv);
                        r_rf[R_WVV] <= t_q'({1'b0, r_vv});
                        r_rf[R_C0]  <= t_q'(r_c0);
                        r_rf[R_C1]  <= t_q'(r_c1);
                        r_rf[R_Y]   <= i_measured_position;
                        r_rf[R_XP]  <= r_est_p;
                        r_rf[R_XV]  <= r_est_v;
                        r_rf[R_PP]  <= r_first ? t_q'({1'b0, r_pp}) : r_cov_pp;
                        r_rf[R_PV]  <= r_first ? t_q'(r_pv) : r_cov_pv;
                        r_rf[R_VV]  <= r_first ? t_q'({1'b0, r_vv}) : r_cov_vv;
                        r_rf[R_ZERO] <= '0;
                        r_first <= 1'b0;
                        r_fault <= 1'b0;
                        r_pc    <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (r_pc == PC_END) begin
                        r_est_p  <= r_rf[R_XP];
                        r_est_v  <= r_rf[R_XV];
                        r_cov_pp <= r_rf[R_PP];
                        r_cov_pv <= r_rf[R_PV];
                        r_cov_vv <= r_rf[R_VV];
                        r_pos    <= r_rf[R_XP];
                        r_vel    <= r_rf[R_XV];
                        r_inn    <= r_rf[R_INN];
                        r_mfault <= r_fault;
                        r_state  <= S_OUT;
                    end else if (w_div_zero) begin
                        // zero innovation variance: gain forced to zero
                        r_rf[w_d] <= '0;
                        r_fault   <= 1'b1;
                        r_pc      <= r_pc + 1'b1;
                    end else begin
                        r_start <= 1'b1;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_done) begin
                        r_rf[w_d] <= w_wr;
                        if (w_sat) r_fault <= 1'b1;
                        r_pc    <= r_pc + 1'b1;
                        r_state <= S_ISSUE;
                    end
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_position_estimate = r_pos;
    assign o_velocity_estimate = r_vel;
    assign o_innovation        = r_inn;
    assign o_math_fault        = r_mfault;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_ISSUE && r_pc == '0))
        else $error("accepted sample did not start program");
    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == S_WAIT) else $error("unit result outside wait");
    a_pc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PC_END) else $error("program counter overran");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_position_estimate))
        else $error("result dropped under stall");
endmodule

// ===== test/kfpv_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kfpv_checker: result predictor and comparator for the tracking filter
// mirrors register writes, predicts each sample's estimates and checks outputs
// ----------------------------------------------------------------------------
module kfpv_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic signed [31:0] i_measured_position,
    input  logic               i_valid_out,
    input  logic               i_ready,
    input  logic signed [31:0] i_position_estimate,
    input  logic signed [31:0] i_velocity_estimate,
    input  logic signed [31:0] i_innovation,
    input  logic               i_math_fault,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_result_count,
    output int                 o_fault_count
);
    import kfpv_pkg::*;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] inn;
        logic               fault;
    } t_estimate;

    t_estimate estimate_q[$];

    logic [30:0]        step_t, meas_var, wpp_r, wvv_r;
    logic signed [31:0] accel_u, wpv_r, cpos, cvel;
    logic signed [31:0] xpos, xvel, ppp, ppv, pvv;
    logic               first_pending;
    bit                 clamp_hit;

    function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            clamp_hit = 1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            clamp_hit = 1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a, b);
        return clamp(64'(a) + 64'(b));
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a, b);
        return clamp(64'(a) - 64'(b));
    endfunction

    // arithmetic shift floors toward minus infinity
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a, b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return clamp(p >>> FRAC_BITS);
    endfunction

    // sv division truncates toward zero
    function automatic logic signed [31:0] qdiv(input logic signed [31:0] n, d);
        logic signed [63:0] num;
        num = 64'(n) <<< FRAC_BITS;
        return clamp(num / 64'(d));
    endfunction

    task automatic predict_sample(input logic signed [31:0] y);
        logic signed [31:0] t, b0, xp, xv, inn, h0, h1, g0, g1, s, k0, k1;
        logic signed [31:0] m00, m01, app, t_e;
        t_estimate e;
        t = $signed({1'b0, step_t});
        clamp_hit = 0;
        if (first_pending) begin
            ppp = $signed({1'b0, wpp_r});
            ppv = wpv_r;
            pvv = $signed({1'b0, wvv_r});
            first_pending = 0;
        end
        t_e = qmul(t, t);
        b0 = t_e / 2;
        xp = qadd(qadd(xpos, qmul(t, xvel)), qmul(b0, accel_u));
        xv = qadd(xvel, qmul(t, accel_u));
        inn = qsub(y, qadd(qmul(cpos, xp), qmul(cvel, xv)));
        h0 = qadd(qmul(ppp, cpos), qmul(ppv, cvel));
        h1 = qadd(qmul(ppv, cpos), qmul(pvv, cvel));
        s = qadd(qadd(qmul(cpos, h0), qmul(cvel, h1)), $signed({1'b0, meas_var}));
        g0 = qadd(h0, qmul(t, h1));
        g1 = h1;
        if (s == 0) begin
            clamp_hit = 1;
            k0 = 0;
            k1 = 0;
        end else begin
            k0 = qdiv(g0, s);
            k1 = qdiv(g1, s);
        end
        xpos = qadd(xp, qmul(k0, inn));
        xvel = qadd(xv, qmul(k1, inn));
        m00 = qadd(ppp, qmul(t, ppv));
        m01 = qadd(ppv, qmul(t, pvv));
        app = qadd(m00, qmul(t, m01));
        ppp = qadd(qsub(app, qmul(k0, g0)), $signed({1'b0, wpp_r}));
        ppv = qadd(qsub(m01, qmul(k0, g1)), wpv_r);
        pvv = qadd(qsub(pvv, qmul(k1, g1)), $signed({1'b0, wvv_r}));
        e.pos = xpos;
        e.vel = xvel;
        e.inn = inn;
        e.fault = clamp_hit;
        estimate_q.push_back(e);
    endtask

    always @(posedge i_clk) begin
        t_estimate e;
        if (!i_rst_n) begin
            step_t        <= 31'd65536;
            accel_u       <= 32'sd65536;
            meas_var      <= 31'd6553600;
            wpp_r         <= 31'd655;
            wpv_r         <= 32'sd1311;
            wvv_r         <= 31'd2621;
            cpos          <= 32'sd65536;
            cvel          <= '0;
            xpos          <= '0;
            xvel          <= '0;
            ppp           <= '0;
            ppv           <= '0;
            pvv           <= '0;
            first_pending <= 1'b1;
            estimate_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_STEP_TIME:     step_t   <= i_cfg_data[30:0];
                    REG_ACCEL_COMMAND: accel_u  <= i_cfg_data;
                    REG_MEAS_VARIANCE: meas_var <= i_cfg_data[30:0];
                    REG_PROC_VAR_PP:   wpp_r    <= i_cfg_data[30:0];
                    REG_PROC_VAR_PV:   wpv_r    <= i_cfg_data;
                    REG_PROC_VAR_VV:   wvv_r    <= i_cfg_data[30:0];
                    REG_MEAS_GAIN_POS: cpos     <= i_cfg_data;
                    REG_MEAS_GAIN_VEL: cvel     <= i_cfg_data;
                    default: ;
                endcase
            end
            // state updates are blocking inside the task; run it before compare
            if (i_valid && i_ready_in)
                predict_sample(i_measured_position);
            if (i_valid_out && i_ready) begin
                o_result_count <= o_result_count + 1;
                if (i_math_fault) o_fault_count <= o_fault_count + 1;
                if (estimate_q.size() == 0) begin
                    $error("unexpected result transaction");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = estimate_q.pop_front();
                    if (e.pos !== i_position_estimate ||
                        e.vel !== i_velocity_estimate ||
                        e.inn !== i_innovation || e.fault !== i_math_fault)
                        o_fail_count <= o_fail_count + 1;
                    if (e.pos !== i_position_estimate)
                        $error("position_estimate exp %0d got %0d", e.pos,
                               i_position_estimate);
                    if (e.vel !== i_velocity_estimate)
                        $error("velocity_estimate exp %0d got %0d", e.vel,
                               i_velocity_estimate);
                    if (e.inn !== i_innovation)
                        $error("innovation exp %0d got %0d", e.inn, i_innovation);
                    if (e.fault !== i_math_fault)
                        $error("math_fault exp %0b got %0b", e.fault, i_math_fault);
                end
            end
        end
        o_pending <= estimate_q.size();
    end

    initial begin
        o_fail_count   = 0;
        o_result_count = 0;
        o_fault_count  = 0;
        o_pending      = 0;
    end
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the position/velocity tracking filter
// drives measurements under several idling mixes and register settings;
// a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb;
    import kfpv_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_measured_position;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_position_estimate;
    logic signed [31:0] o_velocity_estimate;
    logic signed [31:0] o_innovation;
    logic               o_math_fault;

    int fail_count, pending, result_count, fault_count;
    int send_idle_pct, recv_stall_pct;
    int sent;

    kalman_filter_position_velocity u_dut (.*);

    kfpv_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_ready_in(o_ready), .i_measured_position,
        .i_valid_out(o_valid), .i_ready,
        .i_position_estimate(o_position_estimate),
        .i_velocity_estimate(o_velocity_estimate),
        .i_innovation(o_innovation), .i_math_fault(o_math_fault),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count), .o_fault_count(fault_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver: random stalls by current phase percentage
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one measurement transaction, with optional leading idle cycles;
    // valid is left high until the next idle cycle or a wait drops it
    task automatic send_sample(input logic signed [31:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_measured_position <= y;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    // wait until every expected result is back, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || o_valid);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // a realistic tracking setup: small step, modest gains
    task automatic tame_setup();
        write_reg(REG_STEP_TIME, 32'($urandom_range(65536 >> 3, 65536 * 2)));
        write_reg(REG_ACCEL_COMMAND, 32'($signed($urandom_range(0, 131072)) - 65536));
        write_reg(REG_MEAS_VARIANCE, 32'($urandom_range(65536, 65536 * 200)));
        write_reg(REG_PROC_VAR_PP, 32'($urandom_range(0, 65536)));
        write_reg(REG_PROC_VAR_PV, 32'($signed($urandom_range(0, 4000)) - 2000));
        write_reg(REG_PROC_VAR_VV, 32'($urandom_range(0, 65536)));
        write_reg(REG_MEAS_GAIN_POS, 32'($urandom_range(32768, 98304)));
        write_reg(REG_MEAS_GAIN_VEL, 32'($signed($urandom_range(0, 8192)) - 4096));
    endtask

    task automatic random_setup();
        write_reg(REG_STEP_TIME, $urandom);
        write_reg(REG_ACCEL_COMMAND, $urandom);
        write_reg(REG_MEAS_VARIANCE, $urandom);
        write_reg(REG_PROC_VAR_PP, $urandom);
        write_reg(REG_PROC_VAR_PV, $urandom);
        write_reg(REG_PROC_VAR_VV, $urandom);
        write_reg(REG_MEAS_GAIN_POS, $urandom);
        write_reg(REG_MEAS_GAIN_VEL, $urandom);
    endtask

    // noisy track around a ramp, with occasional wild samples
    function automatic logic signed [31:0] track_sample(input int k);
        if ($urandom_range(9) == 0) return $urandom;
        return 32'(k * 3000 + $signed($urandom_range(0, 200000)) - 100000);
    endfunction

    initial begin
        int k;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = '0;
        i_cfg_data          = '0;
        i_valid             = 1'b0;
        i_measured_position = '0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        sent                = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset defaults with field extremes, first sample loads Sw
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(0);
        send_sample(-1);
        send_sample(32'sh0001_0000);
        drain();

        // zero innovation variance: Sz zero and C zero gives s == 0
        write_reg(REG_MEAS_VARIANCE, 0);
        write_reg(REG_MEAS_GAIN_POS, 0);
        write_reg(REG_MEAS_GAIN_VEL, 0);
        send_sample(32'sh0005_0000);
        send_sample(32'sh8000_0000);
        drain();

        // register extremes: saturating products and sums
        write_reg(REG_STEP_TIME, 32'h7FFF_FFFF);
        write_reg(REG_ACCEL_COMMAND, 32'h8000_0000);
        write_reg(REG_MEAS_VARIANCE, 32'h7FFF_FFFF);
        write_reg(REG_PROC_VAR_PP, 32'h7FFF_FFFF);
        write_reg(REG_PROC_VAR_PV, 32'h8000_0000);
        write_reg(REG_PROC_VAR_VV, 32'h7FFF_FFFF);
        write_reg(REG_MEAS_GAIN_POS, 32'h7FFF_FFFF);
        write_reg(REG_MEAS_GAIN_VEL, 32'h8000_0000);
        for (k = 0; k < 4; k++) send_sample(k[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000);
        drain();

        // other extremes: zero step, max accel, negative position gain
        write_reg(REG_STEP_TIME, 0);
        write_reg(REG_ACCEL_COMMAND, 32'h7FFF_FFFF);
        write_reg(REG_PROC_VAR_PP, 0);
        write_reg(REG_PROC_VAR_PV, 32'h7FFF_FFFF);
        write_reg(REG_PROC_VAR_VV, 0);
        write_reg(REG_MEAS_GAIN_POS, 32'hFFFF_0000);
        write_reg(REG_MEAS_GAIN_VEL, 32'h7FFF_FFFF);
        write_reg(REG_MEAS_VARIANCE, 1);
        for (k = 0; k < 4; k++) send_sample($urandom);
        drain();

        // random part: phases of idling, each with fresh register settings
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            if (ph % 3 == 2) random_setup();
            else tame_setup();
            for (k = 0; k < 150; k++) begin
                send_sample((ph % 3 == 2) ? $signed($urandom) : track_sample(k));
                // sender holds off until every result is back
                if (k == 75) begin
                    i_valid <= 1'b0;
                    do @(posedge i_clk); while (pending != 0 || o_valid);
                end
            end
            drain();
        end

        $display("covered %0d samples, %0d results (%0d flagged math fault)",
                 sent, result_count, fault_count);
        $display("12 random phases over four idling mixes plus directed extremes");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // about 1815 samples plus stalls fit far below this
    initial begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
